>>> hw/rtl/tpts_pkg.sv
package tpts_pkg;

   // field widths fixed by the interface
   localparam int CMD_W   = 2;
   localparam int POS_W   = 12;
   localparam int PHYS_W  = 3;
   localparam int LEVEL_W = 3;

   // half of the signed position range, used to bias operands positive
   localparam int POS_HALF = 1 << (POS_W - 1);

   // default grid size
   localparam int DEF_NODES_PER_AXIS = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SHIFT  = 2'd2;

   // result kinds
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_SCROLL = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic mul;
      logic rem;
      logic mem_wr;
      logic mem_rd;
      logic look_out;
      logic col_init;
      logic row_init;
      logic scan_rd;
      logic step;
      logic pend_push;
      logic pend_out;
      logic flush_out;
      logic commit;
   } tpts_ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             col_nz;
      logic             row_nz;
      logic             skip;
      logic             hit;
      logic             pend_valid;
      logic             out_free;
      logic             inner_last;
      logic             outer_last;
      logic             phase_row;
   } tpts_sts_type;

endpackage

>>> hw/rtl/tpts_ctrl.sv
module tpts_ctrl
   import tpts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_stall,
   input  tpts_sts_type     sts,
   output tpts_ctl_type     ctl
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL      = 3'd1;
   localparam logic [2:0] ST_REM      = 3'd2;
   localparam logic [2:0] ST_ACCESS   = 3'd3;
   localparam logic [2:0] ST_LOOK_OUT = 3'd4;
   localparam logic [2:0] ST_SCAN_RD  = 3'd5;
   localparam logic [2:0] ST_SCAN_CHK = 3'd6;
   localparam logic [2:0] ST_FLUSH    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       scan_done;

   // new transactions only while idle
   assign req_stall = (state_ff != ST_IDLE);

   // last entry of the current scan phase
   assign scan_done = sts.inner_last && sts.outer_last;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               if (req_cmd == CMD_LOOKUP || req_cmd == CMD_SET || req_cmd == CMD_SHIFT) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            ctl.rem = 1'b1;
            if (sts.cmd != CMD_SHIFT) begin
               state_in = ST_ACCESS;
            end else if (sts.col_nz) begin
               ctl.col_init = 1'b1;
               state_in     = ST_SCAN_RD;
            end else if (sts.row_nz) begin
               ctl.row_init = 1'b1;
               state_in     = ST_SCAN_RD;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_ACCESS: begin
            if (sts.cmd == CMD_SET) begin
               ctl.mem_wr = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               ctl.mem_rd = 1'b1;
               state_in   = ST_LOOK_OUT;
            end
         end
         ST_LOOK_OUT: begin
            if (sts.out_free) begin
               ctl.look_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            if (sts.skip) begin
               if (!scan_done) begin
                  ctl.step = 1'b1;
               end else if (!sts.phase_row && sts.row_nz) begin
                  ctl.row_init = 1'b1;
               end else begin
                  state_in = ST_FLUSH;
               end
            end else begin
               ctl.scan_rd = 1'b1;
               state_in    = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            // a second hit has to wait until the older one can leave
            if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
               ctl.pend_push = sts.hit;
               ctl.pend_out  = sts.hit && sts.pend_valid;
               if (!scan_done) begin
                  ctl.step = 1'b1;
                  state_in = ST_SCAN_RD;
               end else if (!sts.phase_row && sts.row_nz) begin
                  ctl.row_init = 1'b1;
                  state_in     = ST_SCAN_RD;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               ctl.commit = 1'b1;
               state_in   = ST_IDLE;
            end else if (sts.out_free) begin
               ctl.flush_out = 1'b1;
               ctl.commit    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/tpts_datapath.sv
module tpts_datapath
   import tpts_pkg::*;
#(
   parameter int NODES = DEF_NODES_PER_AXIS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic                     req_resident_in,
   input  logic                     csr_wr,
   input  logic [LEVEL_W-1:0]       csr_page_level,
   input  tpts_ctl_type             ctl,
   output tpts_sts_type             sts,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic                     rsp_kind,
   output logic [PHYS_W-1:0]        rsp_phys_x,
   output logic [PHYS_W-1:0]        rsp_phys_y,
   output logic                     rsp_resident,
   output logic                     rsp_last
);

   localparam int OW    = $clog2(NODES);
   localparam int OW1   = OW + 1;
   localparam int CW    = $clog2(NODES + 1);
   localparam int DEPTH = NODES * NODES;
   localparam int AW    = $clog2(DEPTH);
   localparam int VW    = POS_W + 1;
   // bias is a multiple of the grid size, so the remainder is unchanged
   localparam int BIAS  = NODES * ((POS_HALF + NODES - 1) / NODES);
   // reciprocal precision, exact for every biased operand
   localparam int RS    = VW + OW + 2;
   localparam int PW    = VW + RS;
   localparam int RECIP = ((1 << RS) + NODES - 1) / NODES;

   // (a + b) mod grid size, both below the grid size
   function automatic logic [OW-1:0] wrap_add(input logic [OW-1:0] a, input logic [OW-1:0] b);
      logic [OW1-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= OW1'(NODES)) begin
         s = s - OW1'(NODES);
      end
      return s[OW-1:0];
   endfunction

   // row-major slot address
   function automatic logic [AW-1:0] slot_addr(input logic [OW-1:0] px, input logic [OW-1:0] py);
      return AW'(int'(py) * NODES + int'(px));
   endfunction

   // configuration and window state
   logic [LEVEL_W-1:0] level_ff;
   logic [OW-1:0]      offx_ff;
   logic [OW-1:0]      offy_ff;

   // captured transaction
   logic [CMD_W-1:0]   cmd_ff;
   logic               res_in_ff;
   logic [VW-1:0]      opx_ff;
   logic [VW-1:0]      opy_ff;
   logic               unal_ff;
   logic               dxpos_ff;
   logic               dxneg_ff;
   logic               dypos_ff;
   logic [CW-1:0]      cx_ff;
   logic [CW-1:0]      cy_ff;

   // modulo unit
   logic [VW-1:0]      qx_ff;
   logic [VW-1:0]      qy_ff;
   logic [OW-1:0]      sx_ff;
   logic [OW-1:0]      sy_ff;

   // scan sequencing
   logic               phase_row_ff;
   logic [OW-1:0]      i_ff;
   logic [OW-1:0]      j_ff;
   logic [OW-1:0]      cand_px_ff;
   logic [OW-1:0]      cand_py_ff;
   logic               pend_valid_ff;
   logic [OW-1:0]      pend_px_ff;
   logic [OW-1:0]      pend_py_ff;

   // resident store
   logic               res_mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic               rd_data_ff;
   logic               rd_vld_ff;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [OW-1:0]      rsp_px_ff;
   logic [OW-1:0]      rsp_py_ff;
   logic               rsp_res_ff;
   logic               rsp_last_ff;

   // capture-side decode
   logic signed [POS_W-1:0] shx;
   logic signed [POS_W-1:0] shy;
   logic [POS_W-1:0]        lvl_mask;
   logic                    unal;
   logic signed [POS_W-1:0] op_x;
   logic signed [POS_W-1:0] op_y;
   logic [VW-1:0]           v_x;
   logic [VW-1:0]           v_y;
   logic [VW-1:0]           ext_x;
   logic [VW-1:0]           ext_y;
   logic [VW-1:0]           abs_x;
   logic [VW-1:0]           abs_y;
   logic [CW-1:0]           cx;
   logic [CW-1:0]           cy;

   assign shx      = req_pos_x >>> level_ff;
   assign shy      = req_pos_y >>> level_ff;
   assign lvl_mask = ~({POS_W{1'b1}} << level_ff);
   assign unal     = (|(lvl_mask & req_pos_x)) | (|(lvl_mask & req_pos_y));
   assign op_x     = (req_cmd == CMD_SHIFT) ? shx : req_pos_x;
   assign op_y     = (req_cmd == CMD_SHIFT) ? shy : req_pos_y;
   assign v_x      = {op_x[POS_W-1], op_x} + VW'(BIAS);
   assign v_y      = {op_y[POS_W-1], op_y} + VW'(BIAS);
   assign ext_x    = {shx[POS_W-1], shx};
   assign ext_y    = {shy[POS_W-1], shy};
   assign abs_x    = shx[POS_W-1] ? (~ext_x + 1'b1) : ext_x;
   assign abs_y    = shy[POS_W-1] ? (~ext_y + 1'b1) : ext_y;
   assign cx       = (abs_x > VW'(NODES)) ? CW'(NODES) : abs_x[CW-1:0];
   assign cy       = (abs_y > VW'(NODES)) ? CW'(NODES) : abs_y[CW-1:0];

   // page level register
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (csr_wr) begin
         level_ff <= csr_page_level;
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff    <= req_cmd;
         res_in_ff <= req_resident_in;
         opx_ff    <= v_x;
         opy_ff    <= v_y;
         unal_ff   <= unal;
         dxpos_ff  <= !shx[POS_W-1] && (shx != '0);
         dxneg_ff  <= shx[POS_W-1];
         dypos_ff  <= !shy[POS_W-1] && (shy != '0);
         cx_ff     <= cx;
         cy_ff     <= cy;
      end
   end

   // modulo: quotient by reciprocal, then remainder plus offset
   logic [PW-1:0] prod_x;
   logic [PW-1:0] prod_y;
   logic [VW-1:0] w_x;
   logic [VW-1:0] w_y;

   assign prod_x = PW'(opx_ff) * PW'(RECIP);
   assign prod_y = PW'(opy_ff) * PW'(RECIP);
   assign w_x    = opx_ff - VW'(qx_ff * NODES);
   assign w_y    = opy_ff - VW'(qy_ff * NODES);

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         qx_ff <= prod_x[PW-1:RS];
         qy_ff <= prod_y[PW-1:RS];
      end
      if (ctl.rem) begin
         sx_ff <= wrap_add(w_x[OW-1:0], offx_ff);
         sy_ff <= wrap_add(w_y[OW-1:0], offy_ff);
      end
   end

   // window offset, advanced or cleared at the end of a shift
   always_ff @(posedge clock) begin
      if (reset) begin
         offx_ff <= '0;
         offy_ff <= '0;
      end else if (ctl.commit) begin
         offx_ff <= unal_ff ? '0 : sx_ff;
         offy_ff <= unal_ff ? '0 : sy_ff;
      end
   end

   // scan position to logical and physical page
   logic [CW-1:0] col_cnt;
   logic [CW-1:0] row_cnt;
   logic [CW-1:0] cnt;
   logic [OW-1:0] rev_i;
   logic [OW-1:0] lx;
   logic [OW-1:0] ly;
   logic [OW-1:0] spx;
   logic [OW-1:0] spy;
   logic          skip;

   assign col_cnt = unal_ff ? '0 : cx_ff;
   assign row_cnt = unal_ff ? CW'(NODES) : cy_ff;
   assign cnt     = phase_row_ff ? row_cnt : col_cnt;
   assign rev_i   = OW'(NODES - 1) - i_ff;
   assign lx      = phase_row_ff ? j_ff : (dxpos_ff ? i_ff : rev_i);
   assign ly      = phase_row_ff ? ((unal_ff || dypos_ff) ? i_ff : rev_i) : j_ff;
   assign spx     = wrap_add(lx, offx_ff);
   assign spy     = wrap_add(ly, offy_ff);
   // corner pages were already reported in the column pass
   assign skip    = phase_row_ff && !unal_ff &&
                    ((dxpos_ff && (CW'(j_ff) < cx_ff)) ||
                     (dxneg_ff && (CW'(j_ff) >= (CW'(NODES) - cx_ff))));

   always_ff @(posedge clock) begin
      if (ctl.col_init || ctl.row_init) begin
         phase_row_ff <= ctl.row_init;
         i_ff         <= '0;
         j_ff         <= '0;
      end else if (ctl.step) begin
         if (j_ff == OW'(NODES - 1)) begin
            j_ff <= '0;
            i_ff <= i_ff + 1'b1;
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
      if (ctl.scan_rd) begin
         cand_px_ff <= spx;
         cand_py_ff <= spy;
      end
   end

   // held hit, sent once the next hit or the end of the scan is known
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (ctl.pend_push) begin
         pend_valid_ff <= 1'b1;
      end else if (ctl.flush_out) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pend_push) begin
         pend_px_ff <= cand_px_ff;
         pend_py_ff <= cand_py_ff;
      end
   end

   // resident store, one write and one registered read port
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          rd_en;

   assign wr_addr = slot_addr(sx_ff, sy_ff);
   assign rd_addr = ctl.scan_rd ? slot_addr(spx, spy) : wr_addr;
   assign rd_en   = ctl.mem_rd || ctl.scan_rd;

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         res_mem[wr_addr] <= res_in_ff;
      end
      if (rd_en) begin
         rd_data_ff <= res_mem[rd_addr];
      end
   end

   // per-slot written flags, a slot never written reads as not resident
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.mem_wr) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // output register
   logic out_load;
   logic out_free;
   logic hit;

   assign hit      = rd_vld_ff & rd_data_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = ctl.look_out || ctl.pend_out || ctl.flush_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= ctl.look_out ? KIND_LOOKUP : KIND_SCROLL;
         rsp_px_ff   <= ctl.look_out ? sx_ff : pend_px_ff;
         rsp_py_ff   <= ctl.look_out ? sy_ff : pend_py_ff;
         rsp_res_ff  <= ctl.look_out ? hit : 1'b1;
         rsp_last_ff <= ctl.look_out || ctl.flush_out;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_phys_x   = PHYS_W'(rsp_px_ff);
   assign rsp_phys_y   = PHYS_W'(rsp_py_ff);
   assign rsp_resident = rsp_res_ff;
   assign rsp_last     = rsp_last_ff;

   // status to controller
   always_comb begin
      sts            = '0;
      sts.cmd        = cmd_ff;
      sts.col_nz     = (col_cnt != '0);
      sts.row_nz     = (row_cnt != '0);
      sts.skip       = skip;
      sts.hit        = hit;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
      sts.inner_last = (j_ff == OW'(NODES - 1));
      sts.outer_last = ((CW'(i_ff) + CW'(1)) == cnt);
      sts.phase_row  = phase_row_ff;
   end

endmodule

>>> hw/rtl/toroidal_page_table_scroll_top.sv
// Toroidal page table with a scrolling window.
// req_* carries one transaction: lookup, set resident bit, or shift window.
// rsp_* returns results; rsp_last marks the final result of a transaction.
// csr_* writes the page level; csr_ready is always high, write only while idle.
// A lookup answers once; its result goes through the MUL, REM, ACCESS and
// LOOK_OUT states into the output register, and the next transaction can be
// taken while it is shown. A set gives no result and writes in ACCESS.
// A shift first runs the MUL and REM states of the reciprocal modulo unit, then
// visits each page in SCAN_RD and SCAN_CHK (a corner page skipped in the
// row pass in SCAN_RD only), then finishes in FLUSH; an unaligned shift
// visits all N*N pages. Each visited page is one read of the resident store.
// One result is held back so that the last flag is known when it leaves.
// A stalled receiver holds the output register; the scan then waits when a
// second resident page is found, so no result is lost.
// Reset clears the written flags (so no slot reads resident), the window
// offset, page level and all pending results; no clearing pass is needed.
module toroidal_page_table_scroll_top
   import tpts_pkg::*;
#(
   parameter int NODES_PER_AXIS = DEF_NODES_PER_AXIS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic                     req_resident_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_kind,
   output logic [PHYS_W-1:0]        rsp_phys_x,
   output logic [PHYS_W-1:0]        rsp_phys_y,
   output logic                     rsp_resident,
   output logic                     rsp_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [LEVEL_W-1:0]       csr_page_level
);

   tpts_ctl_type ctl;
   tpts_sts_type sts;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   tpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // table, modulo unit, scan and output register
   tpts_datapath #(
      .NODES (NODES_PER_AXIS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_resident_in (req_resident_in),
      .csr_wr          (csr_valid && csr_ready),
      .csr_page_level  (csr_page_level),
      .ctl             (ctl),
      .sts             (sts),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_phys_x      (rsp_phys_x),
      .rsp_phys_y      (rsp_phys_y),
      .rsp_resident    (rsp_resident),
      .rsp_last        (rsp_last)
   );

endmodule

>>> hw/rtl/tpts_checker.sv
module tpts_checker
   import tpts_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_kind,
   input logic [PHYS_W-1:0]        rsp_phys_x,
   input logic [PHYS_W-1:0]        rsp_phys_y,
   input logic                     rsp_resident,
   input logic                     rsp_last
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // ready for a transaction right after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_phys_x)
         && $stable(rsp_phys_y) && $stable(rsp_resident) && $stable(rsp_last))
      else $error("stalled result changed");

   // a lookup answers with a single result
   a_lookup_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LOOKUP |-> rsp_last)
      else $error("lookup answer without last");

   // only resident pages are reported as scrolled out
   a_scroll_resident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SCROLL |-> rsp_resident)
      else $error("scrolled-out page not resident");

endmodule

bind toroidal_page_table_scroll_top tpts_checker u_tpts_checker (.*);

>>> sim/toroidal_page_table_scroll_top_tb.sv
module toroidal_page_table_scroll_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpts_pkg::*;

   localparam int GRID = DEF_NODES_PER_AXIS;

   // command code the block ignores
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // idle patterns for sender and receiver
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   // an unaligned shift with nothing resident visits every page and reports nothing
   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_ITEMS   = 38;
   // slowest run: ~330 transactions, shifts of up to 64 pages, receiver stalls, plus pauses
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct packed {
      logic              kind;
      logic [PHYS_W-1:0] phys_x;
      logic [PHYS_W-1:0] phys_y;
      logic              resident;
      logic              last;
   } page_result_type;

   typedef struct {
      logic                    cfg_wr;
      logic [LEVEL_W-1:0]      cfg_level;
      logic [CMD_W-1:0]        op;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic                    res;
      logic                    typed;
      logic [PHYS_W-1:0]       tx;
      logic [PHYS_W-1:0]       ty;
      logic                    tres;
   } page_stim_type;

   logic                    clock;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_cmd         = CMD_LOOKUP;
   logic signed [POS_W-1:0] req_pos_x       = '0;
   logic signed [POS_W-1:0] req_pos_y       = '0;
   logic                    req_resident_in = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   logic                    rsp_kind;
   logic [PHYS_W-1:0]       rsp_phys_x;
   logic [PHYS_W-1:0]       rsp_phys_y;
   logic                    rsp_resident;
   logic                    rsp_last;
   logic                    csr_valid       = 1'b0;
   logic                    csr_ready;
   logic [LEVEL_W-1:0]      csr_page_level  = '0;

   // shadow state of the page table
   bit   shadow_resident [GRID*GRID];
   int   shadow_off_x;
   int   shadow_off_y;
   int   shadow_level;

   page_result_type expected_pages[$];
   page_result_type scan_hits[$];
   page_stim_type   directed_rows[$];

   int   mismatch_count;
   int   cycle_count;
   int   idle_mode;
   bit   hold_req;
   bit   hold_done;
   int   lookups_sent, sets_sent, shifts_sent, ignored_sent;
   int   lookup_seen, scroll_seen;

   toroidal_page_table_scroll_top #(
      .NODES_PER_AXIS (GRID)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_resident_in (req_resident_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_phys_x      (rsp_phys_x),
      .rsp_phys_y      (rsp_phys_y),
      .rsp_resident    (rsp_resident),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_page_level  (csr_page_level)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pages still expected",
                  cycle_count, expected_pages.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int wrap_axis(int v);
      int r;
      r = v % GRID;
      if (r < 0) r += GRID;
      return r;
   endfunction

   function automatic int send_pct(int mode);
      return (mode == IDLE_SEND) ? 79 : (mode == IDLE_BOTH) ? 19 : 0;
   endfunction

   function automatic int recv_pct(int mode);
      return (mode == IDLE_RECV) ? 79 : (mode == IDLE_BOTH) ? 19 : 0;
   endfunction

   // queue a scrolled-out page if the slot under logical (lx, ly) is resident
   function automatic void report_slot(int lx, int ly);
      int              sx, sy;
      page_result_type r;
      sx = (lx + shadow_off_x) % GRID;
      sy = (ly + shadow_off_y) % GRID;
      if (shadow_resident[sy*GRID + sx]) begin
         r.kind     = KIND_SCROLL;
         r.phys_x   = PHYS_W'(sx);
         r.phys_y   = PHYS_W'(sy);
         r.resident = 1'b1;
         r.last     = 1'b0;
         scan_hits.insert(scan_hits.size(), r);
      end
   endfunction

   // update the shadow table for one transaction and queue the pages it yields
   function automatic void predict_page_op(input page_stim_type s);
      int              x, y, scale, dx, dy, cx, cy, px, py, line;
      bit              in_col;
      page_result_type r;
      x = s.x;
      y = s.y;
      scan_hits.delete();
      case (s.op)
         CMD_LOOKUP, CMD_SET: begin
            px = (wrap_axis(x) + shadow_off_x) % GRID;
            py = (wrap_axis(y) + shadow_off_y) % GRID;
            if (s.op == CMD_SET) begin
               shadow_resident[py*GRID + px] = s.res;
            end else begin
               r.kind     = KIND_LOOKUP;
               r.phys_x   = PHYS_W'(px);
               r.phys_y   = PHYS_W'(py);
               r.resident = shadow_resident[py*GRID + px];
               r.last     = 1'b0;
               scan_hits.insert(scan_hits.size(), r);
            end
         end
         CMD_SHIFT: begin
            scale = 1 << shadow_level;
            if (x % scale != 0 || y % scale != 0) begin
               // unaligned: whole window reported, offset back to zero
               for (int j = 0; j < GRID; j++)
                  for (int i = 0; i < GRID; i++)
                     report_slot(i, j);
               shadow_off_x = 0;
               shadow_off_y = 0;
            end else begin
               dx = x / scale;
               dy = y / scale;
               cx = (dx < 0) ? -dx : dx;
               cy = (dy < 0) ? -dy : dy;
               if (cx > GRID) cx = GRID;
               if (cy > GRID) cy = GRID;
               // vacated columns
               for (int i = 0; i < cx; i++) begin
                  line = (dx > 0) ? i : GRID - 1 - i;
                  for (int j = 0; j < GRID; j++)
                     report_slot(line, j);
               end
               // vacated rows, corners already covered by the column pass
               for (int i = 0; i < cy; i++) begin
                  line = (dy > 0) ? i : GRID - 1 - i;
                  for (int j = 0; j < GRID; j++) begin
                     in_col = (dx > 0 && j < cx) || (dx < 0 && j >= GRID - cx);
                     if (!in_col) report_slot(j, line);
                  end
               end
               shadow_off_x = (shadow_off_x + wrap_axis(dx)) % GRID;
               shadow_off_y = (shadow_off_y + wrap_axis(dy)) % GRID;
            end
         end
         default: ;
      endcase
      if (scan_hits.size() > 0) scan_hits[scan_hits.size()-1].last = 1'b1;
      foreach (scan_hits[i]) expected_pages.insert(expected_pages.size(), scan_hits[i]);
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void add_row(bit cfg_wr, int cfg_level, logic [CMD_W-1:0] op,
                                   int x, int y, bit res,
                                   bit typed, int tx, int ty, bit tres);
      page_stim_type s;
      s.cfg_wr    = cfg_wr;
      s.cfg_level = LEVEL_W'(cfg_level);
      s.op        = op;
      s.x         = POS_W'(x);
      s.y         = POS_W'(y);
      s.res       = res;
      s.typed     = typed;
      s.tx        = PHYS_W'(tx);
      s.ty        = PHYS_W'(ty);
      s.tres      = tres;
      directed_rows.insert(directed_rows.size(), s);
   endfunction

   // offer one transaction, wait for acceptance, then record what it should yield
   task automatic send_item(input page_stim_type s);
      int              gap;
      page_result_type r;
      gap = 0;
      while ($urandom_range(0, 99) < send_pct(idle_mode)) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= s.op;
      req_pos_x       <= s.x;
      req_pos_y       <= s.y;
      req_resident_in <= s.res;
      do @(posedge clock); while (req_stall);
      case (s.op)
         CMD_LOOKUP: lookups_sent++;
         CMD_SET:    sets_sent++;
         CMD_SHIFT:  shifts_sent++;
         default:    ignored_sent++;
      endcase
      if (s.typed) begin
         r.kind     = KIND_LOOKUP;
         r.phys_x   = s.tx;
         r.phys_y   = s.ty;
         r.resident = s.tres;
         r.last     = 1'b1;
         expected_pages.insert(expected_pages.size(), r);
      end else begin
         predict_page_op(s);
      end
   endtask

   // sender stops and waits for every expected page
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pages.size() != 0);
   endtask

   // drained and given time to finish work that yields nothing
   task automatic settle_block();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_page_level(int lvl);
      csr_valid      <= 1'b1;
      csr_page_level <= LEVEL_W'(lvl);
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      shadow_level = lvl;
   endtask

   // receiver stall, with one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_pct(idle_mode));
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      page_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_kind == KIND_SCROLL) scroll_seen++;
         else lookup_seen++;
         if (expected_pages.size() == 0) begin
            $display("%0t: unexpected transaction kind=%0d x=%0d y=%0d res=%0d last=%0d",
                     $time, rsp_kind, rsp_phys_x, rsp_phys_y, rsp_resident, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_pages.pop_front();
            compare_field("kind", want.kind, rsp_kind);
            compare_field("phys_x", want.phys_x, rsp_phys_x);
            compare_field("phys_y", want.phys_y, rsp_phys_y);
            compare_field("resident", want.resident, rsp_resident);
            compare_field("last", want.last, rsp_last);
         end
      end
   end

   // stimulus
   initial begin
      int            level_plan[8];
      int            pick, scale, dx, dy, k;
      page_stim_type s;

      level_plan = '{0, 7, 3, 1, 5, 2, 6, 4};
      idle_mode  = IDLE_NONE;

      // directed table, level 0 after reset
      add_row(0, 0, CMD_LOOKUP, 0, 0, 0, 1, 0, 0, 0);          // empty table
      add_row(0, 0, CMD_LOOKUP, -2048, 2047, 0, 1, 0, 7, 0);   // position extremes wrap
      add_row(0, 0, CMD_SET, 2047, -2048, 1, 0, 0, 0, 0);
      add_row(0, 0, CMD_LOOKUP, -1, 0, 0, 1, 7, 0, 1);         // negative wraps
      add_row(0, 0, CMD_SET, 3, 4, 1, 0, 0, 0, 0);
      add_row(0, 0, CMD_SET, 0, 7, 1, 0, 0, 0, 0);
      add_row(0, 0, CMD_SET, 5, 5, 1, 0, 0, 0, 0);
      add_row(0, 0, CMD_SET, -3, -3, 0, 0, 0, 0, 0);           // clears slot 5,5
      add_row(0, 0, CMD_LOOKUP, 5, 5, 0, 1, 5, 5, 0);
      add_row(0, 0, CMD_UNUSED, 1, 1, 1, 0, 0, 0, 0);          // ignored command
      add_row(0, 0, CMD_LOOKUP, 3, 4, 0, 1, 3, 4, 1);
      add_row(0, 0, CMD_SHIFT, 0, 0, 0, 0, 0, 0, 0);           // nothing vacated
      add_row(0, 0, CMD_SHIFT, 1, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, CMD_SHIFT, -1, -1, 0, 0, 0, 0, 0);         // corner once
      add_row(0, 0, CMD_SHIFT, 9, -9, 0, 0, 0, 0, 0);          // clamped counts
      add_row(0, 0, CMD_SHIFT, 2047, -2048, 0, 0, 0, 0, 0);
      add_row(0, 0, CMD_LOOKUP, 3, 4, 0, 0, 0, 0, 0);
      add_row(1, 7, CMD_SHIFT, 1, 0, 0, 0, 0, 0, 0);           // unaligned at top level
      add_row(0, 0, CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, CMD_SHIFT, -128, 256, 0, 0, 0, 0, 0);
      add_row(0, 0, CMD_SHIFT, -2048, 1920, 0, 0, 0, 0, 0);
      add_row(1, 2, CMD_SHIFT, 4, 6, 0, 0, 0, 0, 0);           // unaligned in y only
      add_row(0, 0, CMD_SHIFT, 8, -4, 0, 0, 0, 0, 0);
      add_row(0, 0, CMD_LOOKUP, 2047, 2047, 0, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg_wr) begin
            settle_block();
            write_page_level(directed_rows[i].cfg_level);
         end
         send_item(directed_rows[i]);
      end

      // random phases, one page level and idle pattern each
      for (int p = 0; p < 8; p++) begin
         settle_block();
         write_page_level(level_plan[p]);
         idle_mode = p % 4;
         if (p == 0) hold_req = 1'b1;
         scale = 1 << shadow_level;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick    = $urandom_range(0, 99);
            s.cfg_wr = 1'b0;
            s.typed  = 1'b0;
            s.x      = POS_W'($urandom_range(0, 4095));
            s.y      = POS_W'($urandom_range(0, 4095));
            s.res    = ($urandom_range(0, 99) < 65);
            if (pick < 45) s.op = CMD_LOOKUP;
            else if (pick < 80) s.op = CMD_SET;
            else if (pick < 96) s.op = CMD_SHIFT;
            else s.op = CMD_UNUSED;
            if (s.op == CMD_SHIFT) begin
               k = $urandom_range(0, 9);
               if (k < 6) begin
                  // small aligned step
                  dx  = int'($urandom_range(0, 18)) - 9;
                  dy  = int'($urandom_range(0, 18)) - 9;
                  s.x = POS_W'(dx * scale);
                  s.y = POS_W'(dy * scale);
               end else if (k < 8) begin
                  // aligned over the full range
                  s.x = s.x & ~POS_W'(scale - 1);
                  s.y = s.y & ~POS_W'(scale - 1);
               end
            end
            send_item(s);
            // occasional full drain mid-phase
            if ($urandom_range(0, 49) == 0) wait_drained();
         end
      end

      settle_block();
      $display("covered %0d transactions: %0d lookups, %0d sets, %0d shifts, %0d ignored",
               lookups_sent + sets_sent + shifts_sent + ignored_sent,
               lookups_sent, sets_sent, shifts_sent, ignored_sent);
      $display("checked %0d lookup answers and %0d scrolled-out pages, levels 0 to 7",
               lookup_seen, scroll_seen);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
